/* hdl/osst_pkg.sv */
// osst_pkg: shared constants, codes and types for the order-statistic sum tree
// depends on nothing; imported by osst_alu, the core and the checker
package osst_pkg;

    // tree shape: leaves sit at node SPAN + i, root is node 1
    localparam int LEVELS  = 10;
    localparam int SPAN    = 1 << LEVELS;
    localparam int SIZE    = SPAN;
    localparam int NODE_AW = LEVELS + 1;
    localparam int NODES   = 2 * SPAN;

    // field widths
    localparam int ACT_W  = 2;
    localparam int POS_W  = 10;
    localparam int LEAF_W = 16;
    localparam int NODE_W = LEAF_W + LEVELS;
    localparam int RANK_W = 26;

    // action codes
    localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_FIND   = 2'd2;

    // sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_INIT  = 6'b000001,
        ST_IDLE  = 6'b000010,
        ST_UP    = 6'b000100,
        ST_QRY   = 6'b001000,
        ST_FROOT = 6'b010000,
        ST_FDESC = 6'b100000
    } state_t;

    // operand selects of the shared adder
    typedef struct packed {
        logic use_a;
        logic use_b;
    } alu_ctrl_t;

endpackage

/* hdl/osst_ram.sv */
// osst_ram: generic single-write, dual-read RAM with registered read data
// depends on nothing
module osst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] ra_addr,
    input  logic [$clog2(DEPTH)-1:0] rb_addr,
    output logic [WIDTH-1:0]         ra_data,
    output logic [WIDTH-1:0]         rb_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and two registered read ports
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        ra_data <= mem[ra_addr];
        rb_data <= mem[rb_addr];
    end

endmodule

/* hdl/osst_alu.sv */
// osst_alu: shared add and compare unit of the tree walker
// depends on osst_pkg
module osst_alu (
    input  osst_pkg::alu_ctrl_t            ctrl,
    input  logic [osst_pkg::NODE_W-1:0]    acc,
    input  logic [osst_pkg::NODE_W-1:0]    rd_a,
    input  logic [osst_pkg::NODE_W-1:0]    rd_b,
    input  logic [osst_pkg::RANK_W-1:0]    rem,
    output logic [osst_pkg::NODE_W-1:0]    sum,
    output logic [osst_pkg::RANK_W-1:0]    diff,
    output logic                           go_left
);
    import osst_pkg::*;

    logic [NODE_W-1:0] op_a;
    logic [NODE_W-1:0] op_b;

    // accumulate selected node sums
    assign op_a = ctrl.use_a ? rd_a : '0;
    assign op_b = ctrl.use_b ? rd_b : '0;
    assign sum  = acc + op_a + op_b;

    // descent: stay left while the left child covers the remaining rank
    assign go_left = (rd_a >= rem);
    assign diff    = rem - rd_a;

endmodule

/* hdl/order_statistic_sum_tree_core.sv */
// order_statistic_sum_tree_core: sum tree over 1024 leaf counts with update,
// range sum and k-th search; depends on osst_pkg, osst_ram and osst_alu
//
// Usage
//   A command word is taken when start is high and busy is low. action
//   selects update (write leaf_value at position, report the new tree
//   sum), range query (sum of leaves position..range_right) or find (the
//   smallest leaf whose prefix sum reaches rank). Exactly one result word
//   per command appears on total/leaf_index/found with done high for one
//   cycle; the receiver cannot stall, so the word must be taken then.
//   Walk: update does one node read and one parent write per tree level,
//   find one left-child read per level and range query one pass of the
//   two read ports per level; an unused action code needs no walk, and
//   done is a registered pulse. Busy stays high for the whole walk, so
//   one command is handled at a time; a new command may be given in the
//   cycle that done is high.
//   Reset: after rst_n rises, a clearing pass writes all 2047 tree nodes
//   (leaves to one, inner nodes to their subtree sums), one node a cycle,
//   with busy high; commands are taken once it ends.
module order_statistic_sum_tree_core (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [osst_pkg::ACT_W-1:0]   action,
    input  logic [osst_pkg::POS_W-1:0]   position,
    input  logic [osst_pkg::POS_W-1:0]   range_right,
    input  logic [osst_pkg::LEAF_W-1:0]  leaf_value,
    input  logic [osst_pkg::RANK_W-1:0]  rank,
    output logic                         busy,
    output logic                         done,
    output logic [osst_pkg::NODE_W-1:0]  total,
    output logic [osst_pkg::POS_W-1:0]   leaf_index,
    output logic                         found
);
    import osst_pkg::*;

    state_t              state_reg,  state_next;
    logic [NODE_AW-1:0]  node_reg,   node_next;
    logic [NODE_W-1:0]   acc_reg,    acc_next;
    logic [RANK_W-1:0]   rem_reg,    rem_next;
    logic [NODE_AW:0]    lo_reg,     lo_next;
    logic [NODE_AW:0]    hi_reg,     hi_next;
    logic                pend_a_reg, pend_a_next;
    logic                pend_b_reg, pend_b_next;
    logic [POS_W-1:0]    pos_reg,    pos_next;
    logic [NODE_AW-1:0]  clr_reg,    clr_next;
    logic [NODE_W-1:0]   ival_reg,   ival_next;
    logic                done_reg,   done_next;
    logic [NODE_W-1:0]   total_reg,  total_next;
    logic [POS_W-1:0]    index_reg,  index_next;
    logic                found_reg,  found_next;

    logic                we;
    logic [NODE_AW-1:0]  waddr;
    logic [NODE_W-1:0]   wdata;
    logic [NODE_AW-1:0]  ra_addr;
    logic [NODE_AW-1:0]  rb_addr;
    logic [NODE_W-1:0]   ra_data;
    logic [NODE_W-1:0]   rb_data;

    alu_ctrl_t           alu_ctrl;
    logic [NODE_W-1:0]   alu_sum;
    logic [RANK_W-1:0]   alu_diff;
    logic                go_left;

    logic [NODE_AW-1:0]  parent;
    logic [NODE_AW-1:0]  child;
    logic [NODE_AW:0]    hi_dec;
    logic [NODE_AW:0]    lo_inc;
    logic [NODE_AW-1:0]  clr_dec;

    // node sum memory
    osst_ram #(
        .WIDTH (NODE_W),
        .DEPTH (NODES)
    ) u_ram (
        .clk     (clk),
        .we      (we),
        .waddr   (waddr),
        .wdata   (wdata),
        .ra_addr (ra_addr),
        .rb_addr (rb_addr),
        .ra_data (ra_data),
        .rb_data (rb_data)
    );

    // shared add and compare unit
    osst_alu u_alu (
        .ctrl    (alu_ctrl),
        .acc     (acc_reg),
        .rd_a    (ra_data),
        .rd_b    (rb_data),
        .rem     (rem_reg),
        .sum     (alu_sum),
        .diff    (alu_diff),
        .go_left (go_left)
    );

    // address helpers
    assign parent  = {1'b0, node_reg[NODE_AW-1:1]};
    assign child   = {node_reg[NODE_AW-2:0], ~go_left};
    assign hi_dec  = hi_reg - 1'b1;
    assign lo_inc  = lo_reg + {{NODE_AW{1'b0}}, lo_reg[0]};
    assign clr_dec = clr_reg - 1'b1;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        node_next   = node_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        lo_next     = lo_reg;
        hi_next     = hi_reg;
        pend_a_next = 1'b0;
        pend_b_next = 1'b0;
        pos_next    = pos_reg;
        clr_next    = clr_reg;
        ival_next   = ival_reg;
        done_next   = 1'b0;
        total_next  = total_reg;
        index_next  = index_reg;
        found_next  = found_reg;
        we          = 1'b0;
        waddr       = '0;
        wdata       = '0;
        ra_addr     = '0;
        rb_addr     = '0;
        alu_ctrl    = '{use_a: 1'b0, use_b: 1'b0};

        unique case (state_reg)
            // clearing pass, top node index down to the root
            ST_INIT:
            begin
                we       = 1'b1;
                waddr    = clr_reg;
                wdata    = ival_reg;
                clr_next = clr_dec;
                // crossing into the level above doubles the subtree sum
                if ((clr_reg & clr_dec) == '0)
                begin
                    ival_next = {ival_reg[NODE_W-2:0], 1'b0};
                end
                if (clr_reg == NODE_AW'(1))
                begin
                    state_next = ST_IDLE;
                end
            end

            // take a command word
            ST_IDLE:
            begin
                if (start)
                begin
                    pos_next = position;
                    unique case (action)
                        ACT_UPDATE:
                        begin
                            we         = 1'b1;
                            waddr      = {1'b1, position};
                            wdata      = NODE_W'(leaf_value);
                            ra_addr    = {1'b1, position[POS_W-1:1], ~position[0]};
                            acc_next   = NODE_W'(leaf_value);
                            node_next  = {1'b1, position};
                            state_next = ST_UP;
                        end
                        ACT_QUERY:
                        begin
                            acc_next = '0;
                            if (position <= range_right)
                            begin
                                lo_next = {2'b01, position};
                                hi_next = {2'b01, range_right} + 1'b1;
                            end
                            else
                            begin
                                lo_next = '0;
                                hi_next = '0;
                            end
                            state_next = ST_QRY;
                        end
                        ACT_FIND:
                        begin
                            ra_addr    = NODE_AW'(2);
                            rb_addr    = NODE_AW'(1);
                            rem_next   = rank;
                            node_next  = NODE_AW'(1);
                            state_next = ST_FROOT;
                        end
                        default:
                        begin
                            done_next  = 1'b1;
                            total_next = '0;
                            index_next = position;
                            found_next = 1'b0;
                        end
                    endcase
                end
            end

            // walk up: parent = node + sibling
            ST_UP:
            begin
                alu_ctrl  = '{use_a: 1'b1, use_b: 1'b0};
                we        = 1'b1;
                waddr     = parent;
                wdata     = alu_sum;
                acc_next  = alu_sum;
                node_next = parent;
                ra_addr   = {parent[NODE_AW-1:1], ~parent[0]};
                if (parent == NODE_AW'(1))
                begin
                    done_next  = 1'b1;
                    total_next = alu_sum;
                    index_next = pos_reg;
                    found_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            // bottom-up range walk, both bounds per level
            ST_QRY:
            begin
                alu_ctrl = '{use_a: pend_a_reg, use_b: pend_b_reg};
                acc_next = alu_sum;
                if (lo_reg < hi_reg)
                begin
                    ra_addr     = lo_reg[NODE_AW-1:0];
                    rb_addr     = hi_dec[NODE_AW-1:0];
                    pend_a_next = lo_reg[0];
                    pend_b_next = hi_reg[0];
                    lo_next     = {1'b0, lo_inc[NODE_AW:1]};
                    hi_next     = {1'b0, hi_reg[NODE_AW:1]};
                end
                else
                begin
                    done_next  = 1'b1;
                    total_next = alu_sum;
                    index_next = pos_reg;
                    found_next = 1'b0;
                    state_next = ST_IDLE;
                end
            end

            // root check, then descent like the next state
            ST_FROOT, ST_FDESC:
            begin
                if (state_reg == ST_FROOT && (rem_reg == '0 || rem_reg > rb_data))
                begin
                    done_next  = 1'b1;
                    total_next = '0;
                    index_next = '0;
                    found_next = 1'b0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    rem_next  = go_left ? rem_reg : alu_diff;
                    node_next = child;
                    ra_addr   = {child[NODE_AW-2:0], 1'b0};
                    if (child[NODE_AW-1])
                    begin
                        done_next  = 1'b1;
                        total_next = '0;
                        index_next = child[POS_W-1:0];
                        found_next = 1'b1;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        state_next = ST_FDESC;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_INIT;
            clr_reg    <= '1;
            ival_reg   <= NODE_W'(1);
            done_reg   <= 1'b0;
            pend_a_reg <= 1'b0;
            pend_b_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            clr_reg    <= clr_next;
            ival_reg   <= ival_next;
            done_reg   <= done_next;
            pend_a_reg <= pend_a_next;
            pend_b_reg <= pend_b_next;
        end
    end

    // working and result registers
    always_ff @(posedge clk)
    begin
        node_reg  <= node_next;
        acc_reg   <= acc_next;
        rem_reg   <= rem_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        pos_reg   <= pos_next;
        total_reg <= total_next;
        index_reg <= index_next;
        found_reg <= found_next;
    end

    // ports
    assign busy       = (state_reg != ST_IDLE);
    assign done       = done_reg;
    assign total      = total_reg;
    assign leaf_index = index_reg;
    assign found      = found_reg;

endmodule

/* hdl/osst_checker.sv */
// osst_port_checker: port-level assertions for the sum tree core, bound to it
// depends on osst_pkg and order_statistic_sum_tree_core
module osst_port_checker (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [osst_pkg::ACT_W-1:0]   action,
    input  logic                         busy,
    input  logic                         done,
    input  logic [osst_pkg::NODE_W-1:0]  total,
    input  logic                         found
);
    import osst_pkg::*;

    // a tree command keeps the block busy in the next cycle
    a_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (action == ACT_UPDATE || action == ACT_QUERY ||
        action == ACT_FIND) |=> busy)
        else $error("tree command did not raise busy");

    // a result word is only shown once the block is free again
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("done while busy");

    // a successful find reports a zero total
    a_found_total: assert property (@(posedge clk) disable iff (!rst_n)
        done && found |-> total == '0)
        else $error("found with nonzero total");

    // an unused action code answers at once with an empty word
    a_unused: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && action != ACT_UPDATE && action != ACT_QUERY &&
        action != ACT_FIND |=> done && !found && total == '0)
        else $error("unused action not answered");

endmodule

bind order_statistic_sum_tree_core osst_port_checker u_osst_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .action (action),
    .busy   (busy),
    .done   (done),
    .total  (total),
    .found  (found)
);
